// ===== sv/wind_turbine_torque_pitch_law_top_macros.svh =====
// ----------------------------------------------------------------------------
// wind turbine torque/pitch law assertion macros
// shared concurrent assertion forms, clocked on clk, idle in reset
// ----------------------------------------------------------------------------
`ifndef WIND_TURBINE_TORQUE_PITCH_LAW_TOP_MACROS_SVH
`define WIND_TURBINE_TORQUE_PITCH_LAW_TOP_MACROS_SVH

// same-cycle implication
`define WTTP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wttp assertion failed");

// next-cycle implication
`define WTTP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wttp assertion failed");

`endif

// ===== sv/wttp_pkg.sv =====
// ----------------------------------------------------------------------------
// wttp_pkg
// widths, register codes, types and saturation helper of the torque/pitch law
// ----------------------------------------------------------------------------
package wttp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 48;
    localparam int UCFG_W    = DATA_W - 1;
    localparam int SUM_W     = DATA_W + 2;
    localparam int HALF_W    = DATA_W / 2;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int DIV_STEPS = DATA_W + FRAC_BITS;
    localparam int MUL_LAT   = 3;

    localparam int APB_W     = 64;
    localparam int NUM_REGS  = 7;
    localparam int IDX_W     = $clog2(NUM_REGS);
    localparam int ADDR_W    = IDX_W + 3;

    localparam logic [IDX_W-1:0] REG_GAIN_A      = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_K_ALPHA     = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_RATED_POWER = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_PITCH_GAIN  = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_RATED_SPEED = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_RATE_MAX    = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_TIME_STEP   = IDX_W'(6);

    typedef logic signed [DATA_W-1:0] fix_t;
    typedef logic        [DATA_W-1:0] umag_t;
    typedef logic        [UCFG_W-1:0] ucfg_t;
    typedef logic signed [SUM_W-1:0]  wide_t;

    localparam fix_t FIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam fix_t FIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam fix_t GAIN_A_RST  = fix_t'(65536);
    localparam fix_t K_ALPHA_RST = fix_t'(64'd327680000000);
    localparam fix_t PGAIN_RST   = fix_t'(65536);

    typedef struct packed {
        fix_t torque;
        fix_t pitch;
        logic go;
    } div_side_t;

    // saturate a wide signed sum to the fixed-point range
    function automatic fix_t sat_fix(input wide_t v);
        logic all_one;
        logic all_zero;
        all_one  = &v[SUM_W-1:DATA_W-1];
        all_zero = ~|v[SUM_W-1:DATA_W-1];
        if (all_one || all_zero)
            return v[DATA_W-1:0];
        else if (v[SUM_W-1])
            return FIX_MIN;
        else
            return FIX_MAX;
    endfunction

endpackage

// ===== sv/wttp_if.sv =====
// ----------------------------------------------------------------------------
// wttp channel interfaces
// sample channel into the law and command channel out of it
// ----------------------------------------------------------------------------
interface wttp_in_if;
    logic                 valid;
    logic                 ready;
    wttp_pkg::fix_t       gen_speed;
    wttp_pkg::fix_t       gen_accel;
    wttp_pkg::fix_t       power_error;
    wttp_pkg::fix_t       gen_torque;

    modport source (output valid, gen_speed, gen_accel, power_error, gen_torque,
                    input ready);
    modport sink   (input valid, gen_speed, gen_accel, power_error, gen_torque,
                    output ready);
endinterface

interface wttp_out_if;
    logic                 valid;
    logic                 ready;
    wttp_pkg::fix_t       pitch_command;
    wttp_pkg::fix_t       torque_command;

    modport source (output valid, pitch_command, torque_command, input ready);
    modport sink   (input valid, pitch_command, torque_command, output ready);
endinterface

// ===== sv/wind_turbine_torque_pitch_law_top.sv =====
// ----------------------------------------------------------------------------
// wind_turbine_torque_pitch_law_top
// sliding-mode torque law and proportional pitch law, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one sample per transfer: generator speed, acceleration,
//   power error and present torque, all signed q31.16
//   out_ch carries one result per transfer: pitch command and next torque
//   command, both signed q31.16 and saturated
//   apb port holds seven 64-bit registers at byte address 8*index; write them
//   only while no sample is in flight, reads return the stored value
// latency and throughput
//   a sample shows on out_ch 77 cycles after its transfer: input register,
//   three 3-stage multipliers in series, sum stages, a 64-stage divider that
//   yields one quotient bit per stage, rate clamp and output register
//   one sample per cycle sustained; every stage advances together
// reset
//   rst_n clears all valid bits and loads register reset values; payload
//   registers are left as they are
// stall
//   when out_ch is held off with a result waiting, the whole pipe freezes and
//   in_ch.ready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
`include "wind_turbine_torque_pitch_law_top_macros.svh"

module wind_turbine_torque_pitch_law_top (
    input  logic                           clk,
    input  logic                           rst_n,
    wttp_in_if.sink                        in_ch,
    wttp_out_if.source                     out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wttp_pkg::ADDR_W-1:0]    paddr,
    input  logic [wttp_pkg::APB_W-1:0]     pwdata,
    output logic [wttp_pkg::APB_W-1:0]     prdata,
    output logic                           pready
);
    import wttp_pkg::*;

    // side data riding along the three multipliers in series, one struct for each
    typedef struct packed {
        fix_t speed;
        fix_t accel;
        fix_t torque;
        logic perr_pos;
        logic perr_neg;
        logic err_pos;
    } side_a_t;

    typedef struct packed {
        fix_t  t4;
        wide_t t5;
        fix_t  torque;
        fix_t  speed;
        fix_t  pitch;
    } side_b_t;

    typedef struct packed {
        fix_t torque;
        fix_t pitch;
    } side_c_t;

    // ---------------- configuration registers ----------------
    fix_t  gain_a_reg, k_alpha_reg, pitch_gain_reg;
    ucfg_t rated_power_reg, rated_speed_reg, rate_max_reg, time_step_reg;

    logic             cfg_wr;
    logic [IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[ADDR_W-1:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_a_reg      <= GAIN_A_RST;
            k_alpha_reg     <= K_ALPHA_RST;
            rated_power_reg <= '0;
            pitch_gain_reg  <= PGAIN_RST;
            rated_speed_reg <= '0;
            rate_max_reg    <= '0;
            time_step_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_GAIN_A:      gain_a_reg      <= pwdata[DATA_W-1:0];
                REG_K_ALPHA:     k_alpha_reg     <= pwdata[DATA_W-1:0];
                REG_RATED_POWER: rated_power_reg <= pwdata[UCFG_W-1:0];
                REG_PITCH_GAIN:  pitch_gain_reg  <= pwdata[DATA_W-1:0];
                REG_RATED_SPEED: rated_speed_reg <= pwdata[UCFG_W-1:0];
                REG_RATE_MAX:    rate_max_reg    <= pwdata[UCFG_W-1:0];
                REG_TIME_STEP:   time_step_reg   <= pwdata[UCFG_W-1:0];
                default:         ;
            endcase
        end
    end

    // signed registers read back sign-extended, unsigned ones zero-extended
    always_comb
    begin
        case (cfg_idx)
            REG_GAIN_A:      prdata = {{(APB_W-DATA_W){gain_a_reg[DATA_W-1]}}, gain_a_reg};
            REG_K_ALPHA:     prdata = {{(APB_W-DATA_W){k_alpha_reg[DATA_W-1]}}, k_alpha_reg};
            REG_RATED_POWER: prdata = {{(APB_W-UCFG_W){1'b0}}, rated_power_reg};
            REG_PITCH_GAIN:  prdata = {{(APB_W-DATA_W){pitch_gain_reg[DATA_W-1]}},
                                       pitch_gain_reg};
            REG_RATED_SPEED: prdata = {{(APB_W-UCFG_W){1'b0}}, rated_speed_reg};
            REG_RATE_MAX:    prdata = {{(APB_W-UCFG_W){1'b0}}, rate_max_reg};
            REG_TIME_STEP:   prdata = {{(APB_W-UCFG_W){1'b0}}, time_step_reg};
            default:         prdata = '0;
        endcase
    end

    // ---------------- pipeline advance ----------------
    logic  adv;
    logic  out_vld_reg;
    fix_t  pitch_out_reg, torque_out_reg;

    // whole pipe moves unless a finished result is held off
    assign adv         = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // ---------------- stage 0: input register and overspeed error ----------------
    logic  v0_reg;
    fix_t  speed0_reg, accel0_reg, torque0_reg, err0_reg;
    logic  perr_pos0_reg, perr_neg0_reg;
    wide_t err_sum;

    assign err_sum = wide_t'(in_ch.gen_speed) - wide_t'($signed({1'b0, rated_speed_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            speed0_reg    <= in_ch.gen_speed;
            accel0_reg    <= in_ch.gen_accel;
            torque0_reg   <= in_ch.gen_torque;
            perr_pos0_reg <= !in_ch.power_error[DATA_W-1] && (in_ch.power_error != '0);
            perr_neg0_reg <= in_ch.power_error[DATA_W-1];
            err0_reg      <= sat_fix(err_sum);
        end
    end

    // ---------------- multipliers a*speed, a*rated power, pitch gain*error ----------------
    fix_t m_as, m_ar, m_pe;

    wttp_fmul u_mul_as (
        .clk (clk),
        .en  (adv),
        .x   (gain_a_reg),
        .y   (speed0_reg),
        .p   (m_as)
    );

    wttp_fmul u_mul_ar (
        .clk (clk),
        .en  (adv),
        .x   (gain_a_reg),
        .y   ($signed({1'b0, rated_power_reg})),
        .p   (m_ar)
    );

    wttp_fmul u_mul_pe (
        .clk (clk),
        .en  (adv),
        .x   (pitch_gain_reg),
        .y   (err0_reg),
        .p   (m_pe)
    );

    logic    va_reg [1:MUL_LAT];
    side_a_t sa_reg [1:MUL_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= MUL_LAT; i++)
                va_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            va_reg[1] <= v0_reg;
            for (int i = 2; i <= MUL_LAT; i++)
                va_reg[i] <= va_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_reg[1] <= '{speed:    speed0_reg,
                           accel:    accel0_reg,
                           torque:   torque0_reg,
                           perr_pos: perr_pos0_reg,
                           perr_neg: perr_neg0_reg,
                           err_pos:  !err0_reg[DATA_W-1] && (err0_reg != '0)};
            for (int i = 2; i <= MUL_LAT; i++)
                sa_reg[i] <= sa_reg[i-1];
        end
    end

    // ---------------- stage 4: a*speed+accel, sign term, pitch ----------------
    logic    v4_reg;
    side_b_t sb4_reg;
    fix_t    t2_reg;
    side_a_t sa_last;
    wide_t   k_wide;

    assign sa_last = sa_reg[MUL_LAT];
    assign k_wide  = wide_t'(k_alpha_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= va_reg[MUL_LAT];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t2_reg <= sat_fix(wide_t'(m_as) + wide_t'(sa_last.accel));
            sb4_reg.t4     <= m_ar;
            sb4_reg.t5     <= sa_last.perr_pos ? k_wide :
                              (sa_last.perr_neg ? -k_wide : '0);
            sb4_reg.torque <= sa_last.torque;
            sb4_reg.speed  <= sa_last.speed;
            sb4_reg.pitch  <= sa_last.err_pos ? m_pe : '0;
        end
    end

    // ---------------- multiplier torque*(a*speed+accel) ----------------
    fix_t m_t3;

    wttp_fmul u_mul_t3 (
        .clk (clk),
        .en  (adv),
        .x   (sb4_reg.torque),
        .y   (t2_reg),
        .p   (m_t3)
    );

    logic    vb_reg [1:MUL_LAT];
    side_b_t sb_reg [1:MUL_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= MUL_LAT; i++)
                vb_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vb_reg[1] <= v4_reg;
            for (int i = 2; i <= MUL_LAT; i++)
                vb_reg[i] <= vb_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_reg[1] <= sb4_reg;
            for (int i = 2; i <= MUL_LAT; i++)
                sb_reg[i] <= sb_reg[i-1];
        end
    end

    // ---------------- stage 8: numerator, sign test, magnitudes ----------------
    side_b_t   sb_last;
    fix_t      num;
    logic      go;
    logic      v8_reg;
    umag_t     nmag_reg, dmag_reg;
    div_side_t dside8_reg;

    assign sb_last = sb_reg[MUL_LAT];

    always_comb
    begin
        num = sat_fix(wide_t'(m_t3) - wide_t'(sb_last.t4) + sb_last.t5);
        // rate = -num/speed is positive only for opposite signs
        go  = (sb_last.speed != '0) && (num != '0)
              && (num[DATA_W-1] != sb_last.speed[DATA_W-1]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else if (adv)
            v8_reg <= vb_reg[MUL_LAT];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nmag_reg   <= num[DATA_W-1] ? umag_t'(-num) : umag_t'(num);
            dmag_reg   <= sb_last.speed[DATA_W-1] ? umag_t'(-sb_last.speed)
                                                  : umag_t'(sb_last.speed);
            dside8_reg <= '{torque: sb_last.torque, pitch: sb_last.pitch, go: go};
        end
    end

    // ---------------- divider ----------------
    logic                 div_vld;
    logic [DIV_STEPS-1:0] div_q;
    div_side_t            div_side;

    wttp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_vld   (v8_reg),
        .n        (nmag_reg),
        .d        (dmag_reg),
        .side_in  (dside8_reg),
        .out_vld  (div_vld),
        .q        (div_q),
        .side_out (div_side)
    );

    // ---------------- rate clamp ----------------
    logic    vr_reg;
    logic    go_r_reg;
    fix_t    rate_reg;
    side_c_t sr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vr_reg <= 1'b0;
        else if (adv)
            vr_reg <= div_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            go_r_reg <= div_side.go;
            if (!div_side.go)
                rate_reg <= '0;
            else if (div_q > DIV_STEPS'(rate_max_reg))
                rate_reg <= $signed({1'b0, rate_max_reg});
            else
                rate_reg <= $signed({1'b0, div_q[UCFG_W-1:0]});
            sr_reg <= '{torque: div_side.torque, pitch: div_side.pitch};
        end
    end

    // ---------------- multiplier rate*time step ----------------
    fix_t m_dt;

    wttp_fmul u_mul_dt (
        .clk (clk),
        .en  (adv),
        .x   (rate_reg),
        .y   ($signed({1'b0, time_step_reg})),
        .p   (m_dt)
    );

    logic    vc_reg [1:MUL_LAT];
    side_c_t sc_reg [1:MUL_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= MUL_LAT; i++)
                vc_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vc_reg[1] <= vr_reg;
            for (int i = 2; i <= MUL_LAT; i++)
                vc_reg[i] <= vc_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_reg[1] <= sr_reg;
            for (int i = 2; i <= MUL_LAT; i++)
                sc_reg[i] <= sc_reg[i-1];
        end
    end

    // ---------------- output register: integrate torque ----------------
    side_c_t sc_last;
    assign sc_last = sc_reg[MUL_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= vc_reg[MUL_LAT];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            torque_out_reg <= sat_fix(wide_t'(sc_last.torque) + wide_t'(m_dt));
            pitch_out_reg  <= sc_last.pitch;
        end
    end

    assign out_ch.valid          = out_vld_reg;
    assign out_ch.pitch_command  = pitch_out_reg;
    assign out_ch.torque_command = torque_out_reg;

    // ---------------- assertions ----------------
    // a sample transfer never happens while a result is held off
    `WTTP_ASSERT_IMP(a_no_accept_in_stall, in_ch.valid && in_ch.ready, !out_vld_reg || out_ch.ready)
    // clamped rate never exceeds the configured maximum
    `WTTP_ASSERT_IMP(a_rate_in_range, vr_reg, $unsigned(rate_reg) <= umag_t'(rate_max_reg))
    // a nonzero rate only comes out of a division that was enabled
    `WTTP_ASSERT_IMP(a_rate_needs_div, vr_reg && (rate_reg != '0), go_r_reg)
    // a stalled result stays valid and its torque stays put while the pipe is frozen
    `WTTP_ASSERT_NXT(a_freeze_holds, out_vld_reg && !out_ch.ready, $stable(torque_out_reg) && out_vld_reg)

endmodule

// ===== sv/wttp_fmul.sv =====
// ----------------------------------------------------------------------------
// wttp_fmul
// three-stage fixed-point multiply, floor shift and saturation
// ----------------------------------------------------------------------------
module wttp_fmul (
    input  logic           clk,
    input  logic           en,
    input  wttp_pkg::fix_t x,
    input  wttp_pkg::fix_t y,
    output wttp_pkg::fix_t p
);
    import wttp_pkg::*;

    localparam int Q_W = PROD_W - FRAC_BITS;

    umag_t                 mx_reg, my_reg;
    logic                  neg1_reg, neg2_reg;
    logic [2*HALF_W-1:0]   ll_reg, lh_reg, hl_reg, hh_reg;
    fix_t                  p_reg, p_next;

    logic [PROD_W-1:0]     prod;
    logic [Q_W-1:0]        q;
    logic                  rem;
    logic [Q_W:0]          qn;

    // stage 1: magnitudes and result sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg1_reg <= x[DATA_W-1] ^ y[DATA_W-1];
            mx_reg   <= x[DATA_W-1] ? umag_t'(-x) : umag_t'(x);
            my_reg   <= y[DATA_W-1] ? umag_t'(-y) : umag_t'(y);
        end
    end

    // stage 2: half-width partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg2_reg <= neg1_reg;
            ll_reg   <= mx_reg[HALF_W-1:0]      * my_reg[HALF_W-1:0];
            lh_reg   <= mx_reg[HALF_W-1:0]      * my_reg[DATA_W-1:HALF_W];
            hl_reg   <= mx_reg[DATA_W-1:HALF_W] * my_reg[HALF_W-1:0];
            hh_reg   <= mx_reg[DATA_W-1:HALF_W] * my_reg[DATA_W-1:HALF_W];
        end
    end

    // stage 3: sum, floor toward minus infinity, saturate
    always_comb
    begin
        prod = PROD_W'(ll_reg)
             + (PROD_W'(lh_reg) << HALF_W)
             + (PROD_W'(hl_reg) << HALF_W)
             + (PROD_W'(hh_reg) << DATA_W);
        q    = prod[PROD_W-1:FRAC_BITS];
        rem  = |prod[FRAC_BITS-1:0];
        qn   = {1'b0, q} + (Q_W+1)'(rem);
        if (neg2_reg)
        begin
            if (qn >= (Q_W+1)'({1'b1, {(DATA_W-1){1'b0}}}))
                p_next = FIX_MIN;
            else
                p_next = fix_t'(-qn[DATA_W-1:0]);
        end
        else
        begin
            if (q > Q_W'(FIX_MAX))
                p_next = FIX_MAX;
            else
                p_next = fix_t'(q[DATA_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ===== sv/wttp_div.sv =====
// ----------------------------------------------------------------------------
// wttp_div
// pipelined restoring divider, one quotient bit per stage, fraction scaled
// ----------------------------------------------------------------------------
module wttp_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  wttp_pkg::umag_t     n,
    input  wttp_pkg::umag_t     d,
    input  wttp_pkg::div_side_t side_in,
    output logic                out_vld,
    output logic [wttp_pkg::DIV_STEPS-1:0] q,
    output wttp_pkg::div_side_t side_out
);
    import wttp_pkg::*;

    logic                  vld_reg  [1:DIV_STEPS];
    umag_t                 n_reg    [1:DIV_STEPS];
    umag_t                 d_reg    [1:DIV_STEPS];
    umag_t                 r_reg    [1:DIV_STEPS];
    logic [DIV_STEPS-1:0]  q_reg    [1:DIV_STEPS];
    div_side_t             side_reg [1:DIV_STEPS];

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_step
        localparam int BIT_I = DIV_STEPS - 1 - s;

        logic                  vld_in;
        umag_t                 n_in, d_in, r_in, r_next;
        logic [DIV_STEPS-1:0]  q_in;
        div_side_t             side_in_s;
        logic                  nbit;
        logic [DATA_W:0]       r_sh;
        logic                  ge;

        if (s == 0)
        begin : g_first
            assign vld_in    = in_vld;
            assign n_in      = n;
            assign d_in      = d;
            assign r_in      = '0;
            assign q_in      = '0;
            assign side_in_s = side_in;
        end
        else
        begin : g_rest
            assign vld_in    = vld_reg[s];
            assign n_in      = n_reg[s];
            assign d_in      = d_reg[s];
            assign r_in      = r_reg[s];
            assign q_in      = q_reg[s];
            assign side_in_s = side_reg[s];
        end

        if (BIT_I >= FRAC_BITS)
        begin : g_dividend
            assign nbit = n_in[BIT_I-FRAC_BITS];
        end
        else
        begin : g_zero
            assign nbit = 1'b0;
        end

        always_comb
        begin
            r_sh   = {r_in, nbit};
            ge     = r_sh >= {1'b0, d_in};
            r_next = ge ? umag_t'(r_sh - {1'b0, d_in}) : umag_t'(r_sh);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (en)
                vld_reg[s+1] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s+1]    <= n_in;
                d_reg[s+1]    <= d_in;
                r_reg[s+1]    <= r_next;
                q_reg[s+1]    <= {q_in[DIV_STEPS-2:0], ge};
                side_reg[s+1] <= side_in_s;
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STEPS];
    assign q        = q_reg[DIV_STEPS];
    assign side_out = side_reg[DIV_STEPS];

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the torque/pitch law: a directed table, then random
// samples under several register settings, each result checked field by field
// against typed expectations or a bit-true predictor kept in the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import wttp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;  // cycles with no transfer or register access at all
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLD_CYCLES    = 400;    // long receiver hold-off
    localparam int ITEMS_PER_SET  = 170;

    typedef struct packed {
        fix_t speed;
        fix_t accel;
        fix_t perr;
        fix_t torque;
    } sample_t;

    typedef struct packed {
        fix_t pitch;
        fix_t torque;
    } cmd_t;

    // directed row: expectation typed in only where it is obvious
    typedef struct packed {
        sample_t s;
        logic    known;
        cmd_t    c;
    } row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    wttp_in_if  in_ch ();
    wttp_out_if out_ch ();

    wind_turbine_torque_pitch_law_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // register mirror used by the predictor
    longint m_gain_a, m_k_alpha, m_rated_power, m_pitch_gain;
    longint m_rated_speed, m_rate_max, m_time_step;

    cmd_t   cmd_q[$];     // commands still owed by the block
    int     errors;
    int     snd_idle;     // percent of cycles the sender idles
    int     rcv_idle;     // percent of cycles the receiver idles
    bit     hold_req;     // asks the receiver for a long hold-off
    int     quiet_cycles;

    // clock, 4 ns period
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic longint sat48(input longint v);
        if (v > 64'sd140737488355327)
            return 64'sd140737488355327;
        if (v < -64'sd140737488355328)
            return -64'sd140737488355328;
        return v;
    endfunction

    // floor(x*y / 2^frac), saturated
    function automatic longint qmul(input longint x, input longint y);
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] p;
        a = x;
        b = y;
        p = (a * b) >>> FRAC_BITS;
        if (p > 128'sd140737488355327)
            return 64'sd140737488355327;
        if (p < -128'sd140737488355328)
            return -64'sd140737488355328;
        return longint'(p);
    endfunction

    function automatic longint absval(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic cmd_t law_command(input sample_t s);
        longint speed, accel, perr, torque;
        longint t2, t3, t4, t5, num, rate, err;
        logic [79:0] quo;
        cmd_t c;
        speed  = s.speed;
        accel  = s.accel;
        perr   = s.perr;
        torque = s.torque;
        rate   = 0;
        if (speed != 0)
        begin
            t2  = sat48(qmul(m_gain_a, speed) + accel);
            t3  = qmul(torque, t2);
            t4  = qmul(m_gain_a, m_rated_power);
            t5  = (perr > 0) ? m_k_alpha : ((perr < 0) ? -m_k_alpha : 0);
            num = sat48(t3 - t4 + t5);
            // rate = -num/speed survives the clamp only when signs differ
            if (num != 0 && ((num < 0) != (speed < 0)))
            begin
                quo  = {16'b0, 64'(absval(num))} << FRAC_BITS;
                quo  = quo / 80'(absval(speed));
                rate = (quo > 80'(m_rate_max)) ? m_rate_max : longint'(quo);
            end
        end
        c.torque = fix_t'(sat48(torque + qmul(rate, m_time_step)));
        err      = sat48(speed - m_rated_speed);
        c.pitch  = fix_t'((err > 0) ? qmul(m_pitch_gain, err) : 0);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------

    task automatic reg_write(input int idx, input logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 8);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        // keep the mirror in step; unknown indexes are ignored
        case (IDX_W'(idx))
            REG_GAIN_A:      m_gain_a      = longint'(fix_t'(val[47:0]));
            REG_K_ALPHA:     m_k_alpha     = longint'(fix_t'(val[47:0]));
            REG_RATED_POWER: m_rated_power = longint'({17'b0, val[46:0]});
            REG_PITCH_GAIN:  m_pitch_gain  = longint'(fix_t'(val[47:0]));
            REG_RATED_SPEED: m_rated_speed = longint'({17'b0, val[46:0]});
            REG_RATE_MAX:    m_rate_max    = longint'({17'b0, val[46:0]});
            REG_TIME_STEP:   m_time_step   = longint'({17'b0, val[46:0]});
            default: ;
        endcase
    endtask

    // let every sample drain before touching registers
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (cmd_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_regs(input logic [63:0] ga, input logic [63:0] ka,
                             input logic [63:0] rp, input logic [63:0] pg,
                             input logic [63:0] rs, input logic [63:0] rm,
                             input logic [63:0] ts);
        wait_idle();
        reg_write(0, ga);
        reg_write(1, ka);
        reg_write(2, rp);
        reg_write(3, pg);
        reg_write(4, rs);
        reg_write(5, rm);
        reg_write(6, ts);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    function automatic fix_t rnd_fix();
        case ($urandom_range(0, 9))
            0: return FIX_MAX;
            1: return FIX_MIN;
            2: return '0;
            3, 4: return fix_t'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
            5: return fix_t'($signed($urandom_range(0, 2 ** 30)) - 2 ** 29);
            default: return fix_t'({$urandom, $urandom});
        endcase
    endfunction

    function automatic logic [63:0] rnd_ucfg(input int big);
        if (big != 0)
            return {17'b0, 15'($urandom), $urandom};
        return 64'($urandom_range(0, 2 ** 22));
    endfunction

    function automatic logic [63:0] rnd_scfg();
        if ($urandom_range(0, 3) == 0)
            return {{16{1'b0}}, 48'({$urandom, $urandom})};
        return 64'($signed($urandom_range(0, 2 ** 19)) - 2 ** 18);
    endfunction

    // offer one sample and return right after the edge of its transfer
    task automatic send_sample(input sample_t s);
        bit took;
        if ($urandom_range(0, 99) < snd_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < snd_idle)
                @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.gen_speed   <= s.speed;
        in_ch.gen_accel   <= s.accel;
        in_ch.power_error <= s.perr;
        in_ch.gen_torque  <= s.torque;
        do
        begin
            @(negedge clk);
            took = in_ch.ready;
            if (took)
                cmd_q.push_back(law_command(s));
            @(posedge clk);
        end
        while (!took);
    endtask

    task automatic send_random(input int count);
        sample_t s;
        for (int n = 0; n < count; n++)
        begin
            s.speed  = rnd_fix();
            s.accel  = rnd_fix();
            s.perr   = rnd_fix();
            s.torque = rnd_fix();
            if (n == count / 3 && snd_idle != 0)
                hold_req = 1'b1;
            send_sample(s);
        end
    endtask

    // directed rows; reset registers give pitch = max(speed, 0), torque unchanged
    row_t dir_tab[] = '{
        '{'{FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX}, 1'b1, '{FIX_MAX, FIX_MAX}},
        '{'{FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN}, 1'b1, '{fix_t'(0), FIX_MIN}},
        '{'{fix_t'(0), FIX_MAX, FIX_MIN, fix_t'(65536)}, 1'b1,
          '{fix_t'(0), fix_t'(65536)}},
        '{'{fix_t'(1), fix_t'(0), fix_t'(0), fix_t'(-1)}, 1'b1,
          '{fix_t'(1), fix_t'(-1)}},
        '{'{fix_t'(-1), fix_t'(0), fix_t'(1), fix_t'(0)}, 1'b1,
          '{fix_t'(0), fix_t'(0)}},
        '{'{fix_t'(65536), fix_t'(-65536), fix_t'(-1), FIX_MAX}, 1'b1,
          '{fix_t'(65536), FIX_MAX}},
        '{'{fix_t'(-655360), fix_t'(65536), fix_t'(1), fix_t'(131072)}, 1'b1,
          '{fix_t'(0), fix_t'(131072)}},
        '{'{FIX_MAX, FIX_MIN, fix_t'(0), FIX_MIN}, 1'b1, '{FIX_MAX, FIX_MIN}},
        '{'{FIX_MIN, FIX_MAX, FIX_MAX, FIX_MAX}, 1'b1, '{fix_t'(0), FIX_MAX}},
        '{'{fix_t'(3 * 65536), fix_t'(0), fix_t'(-5), fix_t'(-7 * 65536)}, 1'b1,
          '{fix_t'(3 * 65536), fix_t'(-7 * 65536)}},
        '{'{fix_t'(1), fix_t'(1), FIX_MAX, fix_t'(1)}, 1'b1,
          '{fix_t'(1), fix_t'(1)}},
        '{'{fix_t'(-1), fix_t'(-1), FIX_MIN, fix_t'(-1)}, 1'b1,
          '{fix_t'(0), fix_t'(-1)}}
    };

    // walk the table; typed expectations hold only under reset registers
    task automatic walk_table(input bit typed);
        for (int r = 0; r < dir_tab.size(); r++)
        begin
            send_sample(dir_tab[r].s);
            if (typed && dir_tab[r].known)
                cmd_q[cmd_q.size() - 1] = dir_tab[r].c;
        end
    endtask

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    task automatic report(input string what, input fix_t got, input fix_t want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // receiver ready, with the long hold-off counted here
    initial
    begin
        int hold_left;
        hold_left    = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    // compare each transfer on the result side with the oldest expectation
    always @(negedge clk)
    begin
        cmd_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (cmd_q.size() == 0)
            begin
                $display("unexpected result transfer at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = cmd_q.pop_front();
                if (out_ch.pitch_command !== want.pitch)
                    report("pitch_command", out_ch.pitch_command, want.pitch);
                if (out_ch.torque_command !== want.torque)
                    report("torque_command", out_ch.torque_command, want.torque);
            end
        end
    end

    // watchdog: too long without any transfer or register access
    always @(negedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired at %0t", $realtime);
            $display("** wind_turbine_torque_pitch_law_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        errors            = 0;
        quiet_cycles      = 0;
        hold_req          = 1'b0;
        snd_idle          = 0;
        rcv_idle          = 0;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.gen_speed   = '0;
        in_ch.gen_accel   = '0;
        in_ch.power_error = '0;
        in_ch.gen_torque  = '0;
        m_gain_a          = 65536;
        m_k_alpha         = 64'sd327680000000;
        m_rated_power     = 0;
        m_pitch_gain      = 65536;
        m_rated_speed     = 0;
        m_rate_max        = 0;
        m_time_step       = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under reset registers
        snd_idle = 20;
        rcv_idle = 20;
        walk_table(1'b1);

        // all extremes high, then an index past the list that must be ignored
        load_regs({16'h0000, FIX_MAX}, {16'h0000, FIX_MAX}, {17'b0, {47{1'b1}}},
                  {16'h0000, FIX_MAX}, {17'b0, {47{1'b1}}}, {17'b0, {47{1'b1}}},
                  {17'b0, {47{1'b1}}});
        reg_write(NUM_REGS, 64'h0000_0000_0001_0000);
        walk_table(1'b0);

        // opposite extremes
        load_regs({16'hFFFF, FIX_MIN}, {16'hFFFF, FIX_MIN}, 64'd0,
                  {16'hFFFF, FIX_MIN}, 64'd0, 64'd0, 64'd0);
        walk_table(1'b0);

        // moderate gains with an open rate clamp
        load_regs(64'd65536, 64'd3 * 65536, 64'd10 * 65536, 64'd32768,
                  64'd2 * 65536, {17'b0, {47{1'b1}}}, 64'd6554);
        walk_table(1'b0);

        // random part: three idling patterns, two settings each
        for (int ph = 0; ph < 3; ph++)
        begin
            snd_idle = (ph == 0) ? 35 : ((ph == 1) ? 47 : 0);
            rcv_idle = (ph == 0) ? 47 : ((ph == 1) ? 35 : 0);
            load_regs(rnd_scfg(), rnd_scfg(), rnd_ucfg(0), rnd_scfg(),
                      rnd_ucfg(0), rnd_ucfg(ph), rnd_ucfg(0));
            send_random(ITEMS_PER_SET);
            load_regs(rnd_scfg(), rnd_scfg(), rnd_ucfg(1), rnd_scfg(),
                      rnd_ucfg(1), rnd_ucfg(1), rnd_ucfg(ph % 2));
            send_random(ITEMS_PER_SET);
        end

        // drain and finish
        in_ch.valid <= 1'b0;
        while (cmd_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("** wind_turbine_torque_pitch_law_top: PASSED **");
        else
            $display("** wind_turbine_torque_pitch_law_top: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/wttp_pkg.sv
sv/wttp_if.sv
sv/wttp_fmul.sv
sv/wttp_div.sv
sv/wind_turbine_torque_pitch_law_top.sv
sim/tb_top.sv
